/* rtl/stq_pkg.sv */
// ---------------------------------------------------------------------------
// stq_pkg: shared types and constants of the sorted timer event queue
// Widths, operation and result codes, cell entry and command structures.
// ---------------------------------------------------------------------------
package stq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int TIME_W      = 48;
  localparam int TAG_W       = 32;
  localparam int HANDLE_W    = 4;
  localparam int KIND_W      = 3;
  localparam int FUNC_W      = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_EXPIRE = 2'd2,
    FUNC_QUERY  = 2'd3
  } func_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADDED   = 3'd0,
    KIND_FULL    = 3'd1,
    KIND_REMOVED = 3'd2,
    KIND_UNKNOWN = 3'd3,
    KIND_EXPIRED = 3'd4,
    KIND_DONE    = 3'd5,
    KIND_TIMEOUT = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    CELL_NONE,
    CELL_INSERT,
    CELL_DELETE,
    CELL_POP
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic              v;
    logic [TIME_W-1:0] expiry;
    logic [TAG_W-1:0]  tag;
    logic [SLOT_W-1:0] slot;
  } entry_t;

  typedef struct packed {
    cell_op_t          op;
    logic [TIME_W-1:0] expiry;
    logic [TAG_W-1:0]  tag;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] handle;
  } cell_cmd_t;

  typedef struct packed {
    entry_t           head;
    logic             full;
    logic [TAG_W-1:0] rm_tag;
  } chain_stat_t;

endpackage

/* rtl/stq_cell.sv */
// ---------------------------------------------------------------------------
// stq_cell: one position of the sorted queue
// Holds one event and shifts with its neighbors on insert, delete and pop.
// ---------------------------------------------------------------------------
module stq_cell
  import stq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cell_cmd_t        cmd,
  input  entry_t           prev,
  input  logic             prev_flag,
  input  entry_t           next,
  input  logic [TAG_W-1:0] rm_tag_in,
  output entry_t           ent,
  output logic             flag_out,
  output logic [TAG_W-1:0] rm_tag_out
);

  logic   later;
  logic   match;
  logic   hit;
  entry_t new_ent;
  entry_t ent_next;

  assign later = !ent.v || (cmd.expiry < ent.expiry);
  assign match = ent.v && (ent.slot == cmd.handle);
  assign hit   = prev_flag || match;

  assign flag_out   = (cmd.op == CELL_DELETE) ? hit : later;
  assign rm_tag_out = rm_tag_in | (match ? ent.tag : '0);

  always_comb begin
    new_ent.v      = 1'b1;
    new_ent.expiry = cmd.expiry;
    new_ent.tag    = cmd.tag;
    new_ent.slot   = cmd.slot;
    ent_next       = ent;
    case (cmd.op)
      CELL_INSERT: begin
        if (later) begin
          ent_next = prev_flag ? prev : new_ent;
        end
      end
      CELL_DELETE: begin
        if (hit) begin
          ent_next = next;
        end
      end
      CELL_POP: ent_next = next;
      default:  ent_next = ent;
    endcase
  end

  always_ff @(posedge clk) begin
    ent.expiry <= ent_next.expiry;
    ent.tag    <= ent_next.tag;
    ent.slot   <= ent_next.slot;
    if (rst) begin
      ent.v <= 1'b0;
    end else begin
      ent.v <= ent_next.v;
    end
  end

endmodule

/* rtl/stq_ctrl.sv */
// ---------------------------------------------------------------------------
// stq_ctrl: operation sequencer of the sorted timer event queue
// Holds the accepted beat, drives the cell chain, tracks slot use and
// loads the result register.
// ---------------------------------------------------------------------------
module stq_ctrl
  import stq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [FUNC_W-1:0]   func,
  input  logic [TIME_W-1:0]   expiry_time,
  input  logic [TIME_W-1:0]   current_time,
  input  logic [HANDLE_W-1:0] handle,
  input  logic [TAG_W-1:0]    event_tag,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [KIND_W-1:0]   kind,
  output logic [HANDLE_W-1:0] slot,
  output logic [TAG_W-1:0]    tag_out,
  output logic [TIME_W-1:0]   time_left,
  output logic                time_left_valid,
  output logic                last,
  input  chain_stat_t         stat,
  output cell_cmd_t           cmd
);

  state_t                 state;
  state_t                 state_next;
  func_t                  func_r;
  logic [TIME_W-1:0]      expiry_r;
  logic [TIME_W-1:0]      now_r;
  logic [HANDLE_W-1:0]    handle_r;
  logic [TAG_W-1:0]       tag_r;
  logic [QUEUE_DEPTH-1:0] in_use;
  logic [QUEUE_DEPTH-1:0] in_use_next;
  logic [SLOT_W-1:0]      free_slot;
  logic                   known;
  logic                   head_due;
  logic                   can_emit;
  logic                   emit;
  logic                   finish;
  kind_t                  kind_next;
  logic [HANDLE_W-1:0]    slot_next;
  logic [TAG_W-1:0]       tag_next;
  logic [TIME_W-1:0]      left_next;
  logic                   left_valid_next;
  logic                   last_next;

  assign s_tready = (state == ST_IDLE);
  assign can_emit = !m_tvalid || m_tready;
  assign known    = (32'(handle_r) < QUEUE_DEPTH) && in_use[SLOT_W'(handle_r)];
  assign head_due = stat.head.v && (now_r >= stat.head.expiry);

  always_comb begin
    free_slot = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (emit && finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op          = CELL_NONE;
    cmd.expiry      = expiry_r;
    cmd.tag         = tag_r;
    cmd.slot        = free_slot;
    cmd.handle      = SLOT_W'(handle_r);
    in_use_next     = in_use;
    emit            = (state == ST_EXEC) && can_emit;
    finish          = 1'b1;
    kind_next       = KIND_DONE;
    slot_next       = '0;
    tag_next        = '0;
    left_next       = '0;
    left_valid_next = 1'b0;
    case (func_r)
      FUNC_ADD: begin
        if (stat.full) begin
          kind_next = KIND_FULL;
        end else begin
          kind_next = KIND_ADDED;
          slot_next = HANDLE_W'(free_slot);
          if (emit) begin
            cmd.op                 = CELL_INSERT;
            in_use_next[free_slot] = 1'b1;
          end
        end
      end
      FUNC_REMOVE: begin
        slot_next = handle_r;
        if (known) begin
          kind_next = KIND_REMOVED;
          tag_next  = stat.rm_tag;
          if (emit) begin
            cmd.op                           = CELL_DELETE;
            in_use_next[SLOT_W'(handle_r)]   = 1'b0;
          end
        end else begin
          kind_next = KIND_UNKNOWN;
        end
      end
      FUNC_EXPIRE: begin
        if (head_due) begin
          kind_next = KIND_EXPIRED;
          slot_next = HANDLE_W'(stat.head.slot);
          tag_next  = stat.head.tag;
          finish    = 1'b0;
          if (emit) begin
            cmd.op                      = CELL_POP;
            in_use_next[stat.head.slot] = 1'b0;
          end
        end
      end
      FUNC_QUERY: begin
        kind_next       = KIND_TIMEOUT;
        left_valid_next = stat.head.v;
        if (stat.head.v && (now_r < stat.head.expiry)) begin
          left_next = stat.head.expiry - now_r;
        end
      end
      default: kind_next = KIND_DONE;
    endcase
    last_next = finish;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_use   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      in_use <= in_use_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      func_r   <= func_t'(func);
      expiry_r <= expiry_time;
      now_r    <= current_time;
      handle_r <= handle;
      tag_r    <= event_tag;
    end
    if (emit) begin
      kind            <= kind_next;
      slot            <= slot_next;
      tag_out         <= tag_next;
      time_left       <= left_next;
      time_left_valid <= left_valid_next;
      last            <= last_next;
    end
  end

endmodule

/* rtl/sorted_timer_event_queue.sv */
// ---------------------------------------------------------------------------
// sorted_timer_event_queue: timer events kept in expiry order
// A row of cells holds the events sorted by expiry; a sequencer runs add,
// remove, expire and query against the row and returns result beats.
//
//   channel  dir  tdata                                      tuser / tlast
//   s_*      in   expiry_time, current_time, handle, tag     tuser: func
//   m_*      out  slot, tag_out, time_left                   tuser: kind, tlv
//
// One beat in, then one result beat at a time: add, remove and query give
// one result beat, expire gives one per popped event plus a closing beat.
// Beats leave through the single result register, one beat per cycle while m_tready is high.
// Reset empties the queue at once; no clearing pass.
// m_tready low holds the sequencer; the next beat waits in s_* until idle.
// ---------------------------------------------------------------------------
module sorted_timer_event_queue
  import stq_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [47:0] expiry_time, [95:48] current_time, [99:96] handle,
  // [131:100] event_tag, [135:132] zero
  input  logic [135:0] s_tdata,
  // [1:0] func
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [3:0] slot, [35:4] tag_out, [83:36] time_left, [87:84] zero
  output logic [87:0]  m_tdata,
  // [2:0] kind, [3] time_left_valid
  output logic [3:0]   m_tuser,
  output logic         m_tlast
);

  cell_cmd_t           cmd;
  chain_stat_t         stat;
  entry_t              ents   [QUEUE_DEPTH];
  logic                flags  [QUEUE_DEPTH+1];
  logic [TAG_W-1:0]    rmtags [QUEUE_DEPTH+1];
  logic [KIND_W-1:0]   kind;
  logic [HANDLE_W-1:0] slot;
  logic [TAG_W-1:0]    tag_out;
  logic [TIME_W-1:0]   time_left;
  logic                time_left_valid;

  assign flags[0]  = 1'b0;
  assign rmtags[0] = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t prev_ent;
    entry_t next_ent;
    if (i == 0) begin : g_first
      assign prev_ent = '0;
    end else begin : g_mid
      assign prev_ent = ents[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_end
      assign next_ent = '0;
    end else begin : g_inner
      assign next_ent = ents[i+1];
    end
    stq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .prev       (prev_ent),
      .prev_flag  (flags[i]),
      .next       (next_ent),
      .rm_tag_in  (rmtags[i]),
      .ent        (ents[i]),
      .flag_out   (flags[i+1]),
      .rm_tag_out (rmtags[i+1])
    );
  end

  assign stat.head   = ents[0];
  assign stat.full   = ents[QUEUE_DEPTH-1].v;
  assign stat.rm_tag = rmtags[QUEUE_DEPTH];

  stq_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .func            (s_tuser),
    .expiry_time     (s_tdata[47:0]),
    .current_time    (s_tdata[95:48]),
    .handle          (s_tdata[99:96]),
    .event_tag       (s_tdata[131:100]),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .kind            (kind),
    .slot            (slot),
    .tag_out         (tag_out),
    .time_left       (time_left),
    .time_left_valid (time_left_valid),
    .last            (m_tlast),
    .stat            (stat),
    .cmd             (cmd)
  );

  assign m_tdata = {4'b0, time_left, tag_out, slot};
  assign m_tuser = {time_left_valid, kind};

endmodule

/* rtl/stq_checker.sv */
// ---------------------------------------------------------------------------
// stq_checker: port-level checks of the sorted timer event queue
// Watches result beats and input acceptance over time.
// ---------------------------------------------------------------------------
module stq_checker
  import stq_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [87:0]  m_tdata,
  input logic [3:0]   m_tuser,
  input logic         m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  a_expired_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[2:0] == KIND_EXPIRED) |-> !m_tlast)
    else $error("expired beat marked last");

  a_other_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[2:0] != KIND_EXPIRED) |-> m_tlast)
    else $error("closing beat not marked last");

  a_tlv_timeout: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[3] |-> (m_tuser[2:0] == KIND_TIMEOUT))
    else $error("time_left_valid outside timeout answer");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an operation runs");

endmodule

bind sorted_timer_event_queue stq_checker u_stq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
